/* rtl/srgb_mip_box_downsample_defines.svh */
// Assertion macros shared by the mip box downsampler modules.
`ifndef SRGB_MIP_BOX_DOWNSAMPLE_DEFINES_SVH
`define SRGB_MIP_BOX_DOWNSAMPLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SMBD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SMBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/smbd_pkg.sv */
// Constants and table-building functions for the mip box downsampler.
`default_nettype none
package smbd_pkg;

    localparam int SAMPLE_W         = 8;
    localparam int PLAIN_SUM_W      = SAMPLE_W + 2;
    localparam int SEARCH_STEPS     = SAMPLE_W;
    localparam int LIN_ENTRIES      = 256;
    localparam int THR_ENTRIES      = 255;
    localparam int LIN_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = QPTR_W + 1;

    localparam logic [63:0] QONE      = 64'd1 << 31;
    localparam logic [63:0] QHALF     = 64'd1 << 30;
    localparam int          LINEAR_LO = 20;

    // Rounded fixed-point product in Q1.31.
    function automatic logic [63:0] smbd_qmul(input logic [63:0] x, input logic [63:0] y);
        return (x * y + QHALF) >> 31;
    endfunction

    // sRGB-to-linear value of m/510 in Q1.31, evaluated at elaboration only.
    function automatic logic [63:0] smbd_curve_q31(input int unsigned m);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] r2;
        logic [63:0] r4;
        logic [63:0] r5;
        if (m <= LINEAR_LO)
        begin
            return (64'(m) * 64'd5 * QONE + 64'd16473) / 64'd32946;
        end
        t  = ((64'(1000 * m + 28050) << 31) + 64'd269025) / 64'd538050;
        u  = smbd_qmul(t, t);
        lo = 64'd0;
        hi = QONE;
        for (int it = 0; it < 40; it++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                r2  = smbd_qmul(mid, mid);
                r4  = smbd_qmul(r2, r2);
                r5  = smbd_qmul(r4, mid);
                if (r5 <= u)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        return smbd_qmul(u, lo);
    endfunction

    // Curve value narrowed to lin_bits fraction bits, rounding half up.
    function automatic logic [31:0] smbd_lin_entry(input int unsigned m, input int lin_bits);
        logic [63:0] v;
        v = smbd_curve_q31(m);
        return 32'((v + (64'd1 << (30 - lin_bits))) >> (31 - lin_bits));
    endfunction

endpackage
`default_nettype wire

/* rtl/smbd_if.sv */
// Channel interfaces of the mip box downsampler.
`default_nettype none
interface smbd_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] top_left;
    logic [7:0] top_right;
    logic [7:0] bottom_left;
    logic [7:0] bottom_right;

    modport source (output valid, output top_left, output top_right,
                    output bottom_left, output bottom_right, input ready);
    modport sink   (input valid, input top_left, input top_right,
                    input bottom_left, input bottom_right, output ready);
endinterface

interface smbd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] mip_sample;

    modport source (output valid, output mip_sample, input ready);
    modport sink   (input valid, input mip_sample, output ready);
endinterface

interface smbd_cfg_if;
    logic valid;
    logic ready;
    logic srgb_mode;

    modport source (output valid, output srgb_mode, input ready);
    modport sink   (input valid, input srgb_mode, output ready);
endinterface
`default_nettype wire

/* rtl/smbd_front.sv */
// Front stage: accepts a 2x2 block, looks up linear values and forms both sums.
`default_nettype none
module smbd_front
    import smbd_pkg::*;
#(
    parameter int LIN_BITS = LIN_BITS_DEFAULT,
    localparam int LIN_W   = LIN_BITS + 1,
    localparam int SUM_W   = LIN_BITS + 3,
    localparam int Q_W     = 1 + SAMPLE_W + SUM_W
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           srgb_mode,
    smbd_sample_if.sink         samples,
    output logic                q_valid,
    input  wire logic           q_ready,
    output logic [Q_W-1:0]      q_data
);

    logic [LIN_W-1:0]       lin_rom [LIN_ENTRIES];
    logic                   front_valid_reg;
    logic                   mode_reg;
    logic [SAMPLE_W-1:0]    plain_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [PLAIN_SUM_W-1:0] plain_sum;
    logic                   accept;

    for (genvar i = 0; i < LIN_ENTRIES; i++)
    begin : g_lin
        localparam logic [31:0] LIN_VAL = smbd_lin_entry(2 * i, LIN_BITS);
        assign lin_rom[i] = LIN_VAL[LIN_W-1:0];
    end

    assign samples.ready = !front_valid_reg || q_ready;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        sum_next  = SUM_W'(lin_rom[samples.top_left])    + SUM_W'(lin_rom[samples.top_right])
                  + SUM_W'(lin_rom[samples.bottom_left]) + SUM_W'(lin_rom[samples.bottom_right]);
        plain_sum = PLAIN_SUM_W'(samples.top_left)    + PLAIN_SUM_W'(samples.top_right)
                  + PLAIN_SUM_W'(samples.bottom_left) + PLAIN_SUM_W'(samples.bottom_right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            front_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= srgb_mode;
            plain_reg <= plain_sum[PLAIN_SUM_W-1:2];
            sum_reg   <= sum_next;
        end
    end

    assign q_valid = front_valid_reg;
    assign q_data  = {mode_reg, plain_reg, sum_reg};

endmodule
`default_nettype wire

/* rtl/smbd_queue.sv */
// Short first-in first-out queue between the front and back stages.
`default_nettype none
`include "srgb_mip_box_downsample_defines.svh"
module smbd_queue
    import smbd_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SMBD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `SMBD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "lost push")
    `SMBD_ASSERT_IMPL(a_ptr_gap, 1'b1, QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0], "pointer gap differs from count")

endmodule
`default_nettype wire

/* rtl/smbd_back.sv */
// Back stages: binary search of the midpoint thresholds, one result bit a stage.
`default_nettype none
`include "srgb_mip_box_downsample_defines.svh"
module smbd_back
    import smbd_pkg::*;
#(
    parameter int LIN_BITS = LIN_BITS_DEFAULT,
    localparam int LIN_W   = LIN_BITS + 1,
    localparam int SUM_W   = LIN_BITS + 3,
    localparam int Q_W     = 1 + SAMPLE_W + SUM_W
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire logic [Q_W-1:0] q_data,
    smbd_result_if.source       result
);

    localparam int NS = SEARCH_STEPS;

    logic [LIN_W-1:0]    thr_rom      [THR_ENTRIES];

    logic                st_valid_reg [NS];
    logic                st_mode_reg  [NS];
    logic [SAMPLE_W-1:0] st_plain_reg [NS];
    logic [SAMPLE_W-1:0] st_res_reg   [NS];
    logic [SUM_W-1:0]    st_sum_reg   [NS];

    logic                in_valid     [NS];
    logic                in_mode      [NS];
    logic [SAMPLE_W-1:0] in_plain     [NS];
    logic [SAMPLE_W-1:0] in_res       [NS];
    logic [SUM_W-1:0]    in_sum       [NS];
    logic [SAMPLE_W-1:0] cand         [NS];
    logic [SAMPLE_W-1:0] res_next     [NS];
    logic                stg_ready    [NS];
    logic                down_ready   [NS];

    for (genvar t = 0; t < THR_ENTRIES; t++)
    begin : g_thr
        localparam logic [31:0] THR_VAL = smbd_lin_entry(2 * t + 1, LIN_BITS);
        assign thr_rom[t] = THR_VAL[LIN_W-1:0];
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int BIT = NS - 1 - k;

        if (k == 0)
        begin : g_head
            assign in_valid[k] = q_valid;
            assign in_mode[k]  = q_data[Q_W-1];
            assign in_plain[k] = q_data[SUM_W +: SAMPLE_W];
            assign in_sum[k]   = q_data[SUM_W-1:0];
            assign in_res[k]   = '0;
        end
        else
        begin : g_chain
            assign in_valid[k] = st_valid_reg[k-1];
            assign in_mode[k]  = st_mode_reg[k-1];
            assign in_plain[k] = st_plain_reg[k-1];
            assign in_sum[k]   = st_sum_reg[k-1];
            assign in_res[k]   = st_res_reg[k-1];
        end

        if (k == NS - 1)
        begin : g_tail
            assign down_ready[k] = result.ready;
        end
        else
        begin : g_mid
            assign down_ready[k] = stg_ready[k+1];
        end

        assign stg_ready[k] = !st_valid_reg[k] || down_ready[k];
        assign cand[k]      = in_res[k] | SAMPLE_W'(1 << BIT);
        assign res_next[k]  = (in_sum[k] >= {thr_rom[cand[k] - 1'b1], 2'b00}) ? cand[k]
                                                                               : in_res[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            else if (stg_ready[k])
            begin
                st_valid_reg[k] <= in_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_ready[k] && in_valid[k])
            begin
                st_mode_reg[k]  <= in_mode[k];
                st_plain_reg[k] <= in_plain[k];
                st_sum_reg[k]   <= in_sum[k];
                st_res_reg[k]   <= res_next[k];
            end
        end
    end

    assign q_ready           = stg_ready[0];
    assign result.valid      = st_valid_reg[NS-1];
    assign result.mip_sample = st_mode_reg[NS-1] ? st_res_reg[NS-1] : st_plain_reg[NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_check
        localparam logic [SAMPLE_W-1:0] LOW_MASK = SAMPLE_W'((1 << (NS - 1 - k)) - 1);
        `SMBD_ASSERT_NEXT(a_stage_hold, st_valid_reg[k] && !down_ready[k], st_valid_reg[k] && $stable(st_res_reg[k]), "stalled stage changed")
        `SMBD_ASSERT_IMPL(a_low_bits, st_valid_reg[k], (st_res_reg[k] & LOW_MASK) == '0, "undecided result bits set")
        `SMBD_ASSERT_IMPL(a_sum_bound, st_valid_reg[k], st_sum_reg[k] <= (SUM_W'(1) << (LIN_BITS + 2)), "linear sum out of range")
    end

endmodule
`default_nettype wire

/* rtl/srgb_mip_box_downsample.sv */
// Top level of the sRGB-aware 2x2 box downsampler for mip chain generation.
//
//   Channel   Direction  Beat carries
//   samples   in         top_left, top_right, bottom_left, bottom_right
//   result    out        mip_sample
//   cfg       in         srgb_mode
//
// One beat is accepted every cycle while the result side does not stall, and each
// beat passes through the front lookup register, the queue slot and the eight
// threshold search stages, one result bit per stage, to give one result beat.
// Reset sets srgb_mode to one and empties every stage; no clearing pass is needed.
// A stall on the result side fills the search stages, then the queue and then the
// front register, thirteen beats in all, before the sample channel drops ready.
`default_nettype none
module srgb_mip_box_downsample
    import smbd_pkg::*;
#(
    parameter int LIN_BITS = LIN_BITS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    smbd_sample_if.sink   samples,
    smbd_result_if.source result,
    smbd_cfg_if.sink      cfg
);

    localparam int SUM_W = LIN_BITS + 3;
    localparam int Q_W   = 1 + SAMPLE_W + SUM_W;

    logic           srgb_mode_reg;
    logic           fq_valid;
    logic           fq_ready;
    logic [Q_W-1:0] fq_data;
    logic           qb_valid;
    logic           qb_ready;
    logic [Q_W-1:0] qb_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srgb_mode_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            srgb_mode_reg <= cfg.srgb_mode;
        end
    end

    smbd_front #(
        .LIN_BITS (LIN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .srgb_mode (srgb_mode_reg),
        .samples   (samples),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    smbd_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    smbd_back #(
        .LIN_BITS (LIN_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .result  (result)
    );

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the sRGB-aware 2x2 box downsampler, with its own table-based predictor.
`timescale 1ns / 1ps
module testbench;
    import smbd_pkg::*;

    localparam int   LIN_W          = LIN_BITS_DEFAULT;
    localparam logic MODE_PLAIN     = 1'b0;
    localparam logic MODE_SRGB      = 1'b1;
    localparam int   PREDICTED      = -1;
    localparam int   STALL_CYCLES   = 80;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 12;
    localparam int   PHASE_ITEMS    = 290;
    localparam int   FINAL_ITEMS    = 100;
    localparam int   NUM_PHASES     = 5;
    localparam int   NUM_ROWS       = 21;
    localparam int   MAX_PRINTED    = 100;

    typedef struct packed {
        logic       mode;
        logic [7:0] top_left;
        logic [7:0] top_right;
        logic [7:0] bottom_left;
        logic [7:0] bottom_right;
        int         want;
    } quad_row_t;

    logic clk;
    logic rst_n;

    smbd_sample_if samples_ch ();
    smbd_result_if result_ch ();
    smbd_cfg_if    cfg_ch ();

    srgb_mip_box_downsample #(
        .LIN_BITS (LIN_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    logic [31:0] linear_of_code  [LIN_ENTRIES];
    logic [31:0] midpoint_linear [THR_ENTRIES];
    logic [7:0]  expected_mips [$];
    logic        srgb_mode_q;
    int          error_count;
    logic        recv_idling;
    int          hold_token;
    int          hold_seen;
    int          hold_left;
    int          recv_burst_left;
    bit          send_idling;
    int          quiet_cycles;

    quad_row_t directed_rows [NUM_ROWS] = '{
        '{MODE_SRGB,  8'd0,   8'd0,   8'd0,   8'd0,   0},
        '{MODE_SRGB,  8'd255, 8'd255, 8'd255, 8'd255, 255},
        '{MODE_SRGB,  8'd255, 8'd0,   8'd0,   8'd0,   PREDICTED},
        '{MODE_SRGB,  8'd0,   8'd0,   8'd0,   8'd255, PREDICTED},
        '{MODE_SRGB,  8'd1,   8'd2,   8'd3,   8'd4,   PREDICTED},
        '{MODE_SRGB,  8'd10,  8'd10,  8'd11,  8'd11,  PREDICTED},
        '{MODE_SRGB,  8'd128, 8'd128, 8'd128, 8'd128, PREDICTED},
        '{MODE_SRGB,  8'd255, 8'd255, 8'd255, 8'd254, PREDICTED},
        '{MODE_SRGB,  8'd170, 8'd85,  8'd51,  8'd204, PREDICTED},
        '{MODE_SRGB,  8'd0,   8'd255, 8'd0,   8'd255, PREDICTED},
        '{MODE_PLAIN, 8'd0,   8'd0,   8'd0,   8'd0,   0},
        '{MODE_PLAIN, 8'd255, 8'd255, 8'd255, 8'd255, 255},
        '{MODE_PLAIN, 8'd255, 8'd255, 8'd255, 8'd254, 254},
        '{MODE_PLAIN, 8'd0,   8'd0,   8'd0,   8'd3,   0},
        '{MODE_PLAIN, 8'd0,   8'd0,   8'd0,   8'd4,   1},
        '{MODE_PLAIN, 8'd255, 8'd0,   8'd0,   8'd0,   63},
        '{MODE_PLAIN, 8'd128, 8'd127, 8'd128, 8'd127, 127},
        '{MODE_PLAIN, 8'd85,  8'd170, 8'd51,  8'd204, 127},
        '{MODE_SRGB,  8'd0,   8'd0,   8'd0,   8'd0,   0},
        '{MODE_SRGB,  8'd255, 8'd255, 8'd255, 8'd255, 255},
        '{MODE_SRGB,  8'd1,   8'd0,   8'd0,   8'd0,   PREDICTED}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] q31_mul(input logic [63:0] x, input logic [63:0] y);
        return (x * y + (64'd1 << 30)) >> 31;
    endfunction

    // Linear-light value of the sRGB level m/510, in unsigned Q1.31.
    function automatic logic [63:0] srgb_curve_q31(input int unsigned m);
        logic [63:0] base;
        logic [63:0] base_sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] probe;
        logic [63:0] p2;
        logic [63:0] p4;
        if (m <= 20)
        begin
            return (64'(m) * 64'd5 * (64'd1 << 31) + 64'd16473) / 64'd32946;
        end
        base    = ((64'(1000 * m + 28050) << 31) + 64'd269025) / 64'd538050;
        base_sq = q31_mul(base, base);
        lo      = 64'd0;
        hi      = 64'd1 << 31;
        while (lo < hi)
        begin
            probe = (lo + hi + 64'd1) >> 1;
            p2    = q31_mul(probe, probe);
            p4    = q31_mul(p2, p2);
            if (q31_mul(p4, probe) <= base_sq)
            begin
                lo = probe;
            end
            else
            begin
                hi = probe - 64'd1;
            end
        end
        return q31_mul(base_sq, lo);
    endfunction

    function automatic logic [31:0] narrow_to_lin(input logic [63:0] v);
        return 32'((v + (64'd1 << (30 - LIN_W))) >> (31 - LIN_W));
    endfunction

    task automatic build_srgb_tables();
        for (int i = 0; i < LIN_ENTRIES; i++)
        begin
            linear_of_code[i] = narrow_to_lin(srgb_curve_q31(2 * i));
        end
        for (int k = 0; k < THR_ENTRIES; k++)
        begin
            midpoint_linear[k] = narrow_to_lin(srgb_curve_q31(2 * k + 1));
        end
    endtask

    function automatic logic [7:0] predict_mip_sample(input logic mode, input logic [31:0] quad);
        logic [63:0] lin_sum;
        logic [9:0]  raw_sum;
        int          reached;
        if (mode == MODE_SRGB)
        begin
            lin_sum = 64'(linear_of_code[quad[31:24]]) + 64'(linear_of_code[quad[23:16]])
                    + 64'(linear_of_code[quad[15:8]]) + 64'(linear_of_code[quad[7:0]]);
            reached = 0;
            for (int k = 0; k < THR_ENTRIES; k++)
            begin
                if (lin_sum >= 64'd4 * 64'(midpoint_linear[k]))
                begin
                    reached++;
                end
            end
            return 8'(reached);
        end
        raw_sum = 10'(quad[31:24]) + 10'(quad[23:16]) + 10'(quad[15:8]) + 10'(quad[7:0]);
        return raw_sum[9:2];
    endfunction

    function automatic logic [31:0] random_quad();
        logic [7:0] lane [4];
        logic [7:0] base;
        logic [7:0] other;
        int         kind;
        int         shifted;
        kind  = $urandom_range(0, 9);
        base  = 8'($urandom());
        other = 8'($urandom());
        for (int j = 0; j < 4; j++)
        begin
            case (kind)
                4: lane[j] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                5:
                begin
                    shifted = int'(base) + $urandom_range(0, 6) - 3;
                    lane[j] = (shifted < 0) ? 8'd0 : (shifted > 255) ? 8'd255 : 8'(shifted);
                end
                6: lane[j] = 8'($urandom_range(0, 12));
                7: lane[j] = 8'($urandom_range(240, 255));
                8: lane[j] = base;
                9: lane[j] = $urandom_range(0, 1) ? base : other;
                default: lane[j] = 8'($urandom());
            endcase
        end
        return {lane[0], lane[1], lane[2], lane[3]};
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic push_quad(input logic [31:0] quad, input int want);
        if (send_idling && ($urandom_range(0, 3) == 0))
        begin
            samples_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.top_left     <= quad[31:24];
        samples_ch.top_right    <= quad[23:16];
        samples_ch.bottom_left  <= quad[15:8];
        samples_ch.bottom_right <= quad[7:0];
        @(posedge clk);
        while (!samples_ch.ready)
        begin
            @(posedge clk);
        end
        if (want == PREDICTED)
        begin
            expected_mips.push_back(predict_mip_sample(srgb_mode_q, quad));
        end
        else
        begin
            expected_mips.push_back(8'(want));
        end
    endtask

    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_mips.size() != 0);
    endtask

    task automatic write_srgb_mode(input logic mode);
        drain_results();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.srgb_mode <= mode;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        srgb_mode_q  = mode;
    endtask

    initial
    begin
        logic phase_mode [NUM_PHASES];
        phase_mode = '{MODE_PLAIN, MODE_SRGB, MODE_PLAIN, MODE_SRGB, MODE_PLAIN};
        error_count             = 0;
        srgb_mode_q             = MODE_SRGB;
        send_idling             = 1'b0;
        recv_idling             = 1'b0;
        hold_token              = 0;
        rst_n                   = 1'b0;
        clk                     = 1'b0;
        samples_ch.valid        = 1'b0;
        samples_ch.top_left     = 8'd0;
        samples_ch.top_right    = 8'd0;
        samples_ch.bottom_left  = 8'd0;
        samples_ch.bottom_right = 8'd0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.srgb_mode        = MODE_SRGB;
        build_srgb_tables();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].mode != srgb_mode_q)
            begin
                write_srgb_mode(directed_rows[r].mode);
            end
            push_quad({directed_rows[r].top_left, directed_rows[r].top_right,
                       directed_rows[r].bottom_left, directed_rows[r].bottom_right},
                      directed_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_srgb_mode(phase_mode[p]);
            send_idling = (p != 2);
            recv_idling <= (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 100)
                begin
                    hold_token <= hold_token + 1;
                end
                if (p == 1 && n == 200)
                begin
                    drain_results();
                end
                push_quad(random_quad(), PREDICTED);
            end
        end

        write_srgb_mode(MODE_SRGB);
        send_idling = 1'b0;
        recv_idling <= 1'b0;
        for (int n = 0; n < FINAL_ITEMS; n++)
        begin
            push_quad(random_quad(), PREDICTED);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        logic [7:0] want_mip;
        result_ch.ready = 1'b0;
        hold_seen       = 0;
        hold_left       = 0;
        recv_burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_mips.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                                              result_ch.mip_sample));
                end
                else
                begin
                    want_mip = expected_mips.pop_front();
                    if (result_ch.mip_sample !== want_mip)
                    begin
                        report_mismatch($sformatf("mip_sample %0d, expected %0d",
                                                  result_ch.mip_sample, want_mip));
                    end
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_idling && recv_burst_left > 0)
            begin
                recv_burst_left--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_idling && $urandom_range(0, 5) == 0)
            begin
                recv_burst_left = $urandom_range(1, 11) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= rst_n;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
